[design/i2c_rbm_pkg.sv]
// ============================================================================
// I2C register burst master - shared definitions
// Bus phase codes, command codes, byte kinds, register indexes and the result
// record passed from the engine to the output register.
// ============================================================================
package i2c_rbm_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN_WR = 2'd1;
    localparam logic [1:0] FUNC_BEGIN_RD = 2'd2;
    localparam logic [1:0] FUNC_WBYTE = 2'd3;

    // Bus phase codes.
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_HI  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_LO  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TX_LOW    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TX_HIGH   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_TACK_LOW  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TACK_HIGH = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RX_LOW    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RX_HIGH   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_MACK_LOW  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_MACK_HIGH = 4'd10;
    localparam logic [PHASE_W-1:0] PH_STOP_LOW  = 4'd11;
    localparam logic [PHASE_W-1:0] PH_STOP_HIGH = 4'd12;
    localparam logic [PHASE_W-1:0] PH_REP_PREP  = 4'd13;
    localparam logic [PHASE_W-1:0] PH_WAIT_BYTE = 4'd14;

    // Kind of byte being shifted out.
    localparam logic [1:0] KIND_ADDR_W = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_ADDR_R = 2'd2;
    localparam logic [1:0] KIND_DATA   = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic CFG_DEV_ADDR  = 1'b0;
    localparam logic CFG_TICKS     = 1'b1;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd104;
    localparam logic [7:0] TICKS_RESET    = 8'd1;

    // One result record.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_byte;
        logic       ack_missing;
        logic       busy_res;
        logic       last_byte;
    } t_result;

endpackage

[design/i2c_register_burst_master.sv]
// ============================================================================
// I2C register burst master
// Register read and write bursts over I2C, driven one command or tick per
// transfer, producing one status/bus-level result per transfer.
// ============================================================================
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         i_s_axis_tvalid/o_..ready tdata 32b, tuser 2b (func)
// m_axis    out        o_m_axis_tvalid/i_..ready tdata 16b, tlast (last_byte)
// cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index 1b, i_cfg_data 8b
//
// Each input transfer produces exactly one output transfer, by way of the input
// register and then the output register. A new input transfer is taken every
// clock unless the output stalls; the sequencer's next state is combinational.
// A stalled output holds its result, and the input register then holds its
// item, so the input side stalls one transfer later.
// Reset (synchronous, active low) empties both registers and returns the
// sequencer to idle with address 104 and a phase length of one tick.
// The configuration channel is always ready; writes are registered in the configuration block.
//
module i2c_register_burst_master
    import i2c_rbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] reg_addr, [15:8] byte_count, [23:16] write_byte, [24] sda_in, rest zero
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  i_s_axis_tuser,
    // Result channel.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] scl_level, [1] sda_level, [9:2] read_byte, [10] read_valid,
    // [11] need_byte, [12] ack_missing, [13] busy_res, [15:14] zero
    output logic [15:0] o_m_axis_tdata,
    // last_byte
    output logic        o_m_axis_tlast,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Input register.
    logic        r_in_vld;
    logic [1:0]  r_func;
    logic [7:0]  r_reg_addr;
    logic [7:0]  r_byte_count;
    logic [7:0]  r_write_byte;
    logic        r_sda_in;

    // Output register.
    logic        r_out_vld;
    t_result     r_res;

    logic        in_take;
    logic        advance;
    logic [6:0]  dev_addr;
    logic [7:0]  ticks;
    t_result     res;

    // The item in the input register moves through the sequencer whenever the
    // output register is free or is being emptied in this cycle.
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func       <= i_s_axis_tuser;
            r_reg_addr   <= i_s_axis_tdata[7:0];
            r_byte_count <= i_s_axis_tdata[15:8];
            r_write_byte <= i_s_axis_tdata[23:16];
            r_sda_in     <= i_s_axis_tdata[24];
        end
    end

    i2c_rbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_valid),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_dev_addr (dev_addr),
        .o_ticks    (ticks)
    );

    // The sequencer state steps exactly once per item, in the cycle the item
    // leaves the input register.
    i2c_rbm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_func       (r_func),
        .i_reg_addr   (r_reg_addr),
        .i_byte_count (r_byte_count),
        .i_write_byte (r_write_byte),
        .i_sda_in     (r_sda_in),
        .i_dev_addr   (dev_addr),
        .i_ticks      (ticks),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_res.busy_res, r_res.ack_missing, r_res.need_byte,
                              r_res.read_valid, r_res.read_byte, r_res.sda_level,
                              r_res.scl_level};
    assign o_m_axis_tlast  = r_res.last_byte;

endmodule

[design/i2c_rbm_cfg.sv]
// ============================================================================
// I2C register burst master - configuration registers
// Holds the target address and the phase length, written over the
// configuration channel.
// ============================================================================
module i2c_rbm_cfg
    import i2c_rbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_we,
    input  logic       i_index,
    input  logic [7:0] i_data,
    output logic [6:0] o_dev_addr,
    output logic [7:0] o_ticks
);

    logic [6:0] r_dev_addr;
    logic [7:0] r_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
            r_ticks    <= TICKS_RESET;
        end else if (i_we) begin
            case (i_index)
                CFG_DEV_ADDR: r_dev_addr <= i_data[6:0];
                CFG_TICKS:    r_ticks    <= i_data;
                default:      r_ticks    <= r_ticks;
            endcase
        end
    end

    assign o_dev_addr = r_dev_addr;
    assign o_ticks    = r_ticks;

endmodule

[design/i2c_rbm_engine.sv]
// ============================================================================
// I2C register burst master - bus sequencer
// Holds the transaction state and computes, for one command or tick, the next
// state and the bus levels and status that follow from it.
// ============================================================================
module i2c_rbm_engine
    import i2c_rbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_func,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_write_byte,
    input  logic       i_sda_in,
    input  logic [6:0] i_dev_addr,
    input  logic [7:0] i_ticks,
    output t_result    o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0] r_div, n_div;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_left, n_left;
    logic [7:0] r_reg, n_reg;
    logic       r_is_read, n_is_read;
    logic       r_ready, n_ready;
    logic [1:0] r_kind, n_kind;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic       r_rx_final, n_rx_final;
    logic       r_nack, n_nack;

    logic [7:0] period;
    logic [7:0] left_dec;
    logic [7:0] rx_shift;
    logic       phase_end;
    logic       got;
    logic       scl;
    logic       sdo;

    assign period    = (i_ticks == 8'd0) ? 8'd1 : i_ticks;
    assign phase_end = ({1'b0, r_div} + 9'd1) >= {1'b0, period};
    assign left_dec  = (r_left != 8'd0) ? (r_left - 8'd1) : 8'd0;
    assign rx_shift  = {r_shift[6:0], i_sda_in};

    always_comb begin
        n_phase    = r_phase;
        n_div      = r_div;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_left     = r_left;
        n_reg      = r_reg;
        n_is_read  = r_is_read;
        n_ready    = r_ready;
        n_kind     = r_kind;
        n_rx_hold  = r_rx_hold;
        n_rx_final = r_rx_final;
        n_nack     = r_nack;
        got        = 1'b0;

        if (i_func == FUNC_BEGIN_WR || i_func == FUNC_BEGIN_RD) begin
            if (r_phase == PH_IDLE) begin
                n_reg     = i_reg_addr;
                n_left    = (i_byte_count == 8'd0) ? 8'd1 : i_byte_count;
                n_is_read = (i_func == FUNC_BEGIN_RD);
                n_shift   = {i_dev_addr, 1'b0};
                n_kind    = KIND_ADDR_W;
                n_bit     = 3'd0;
                n_ready   = 1'b0;
                n_div     = 8'd0;
                n_nack    = 1'b0;
                n_phase   = PH_START_HI;
            end
        end else if (i_func == FUNC_WBYTE) begin
            if (r_phase == PH_WAIT_BYTE && !r_ready) begin
                n_shift = i_write_byte;
                n_ready = 1'b1;
            end
        end else if (r_phase == PH_WAIT_BYTE) begin
            if (r_ready) begin
                n_ready = 1'b0;
                n_div   = 8'd0;
                n_kind  = KIND_DATA;
                n_bit   = 3'd0;
                n_phase = PH_TX_LOW;
            end
        end else if (r_phase != PH_IDLE) begin
            if (!phase_end) begin
                n_div = r_div + 8'd1;
            end else begin
                n_div = 8'd0;
                case (r_phase)
                    PH_START_HI: n_phase = PH_START_LO;
                    PH_START_LO: begin
                        n_bit   = 3'd0;
                        n_phase = PH_TX_LOW;
                    end
                    PH_TX_LOW: n_phase = PH_TX_HIGH;
                    PH_TX_HIGH: begin
                        if (r_bit == 3'd7) begin
                            n_phase = PH_TACK_LOW;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_shift = {r_shift[6:0], 1'b0};
                            n_phase = PH_TX_LOW;
                        end
                    end
                    PH_TACK_LOW: n_phase = PH_TACK_HIGH;
                    PH_TACK_HIGH: begin
                        if (i_sda_in) begin
                            n_nack = 1'b1;
                        end
                        case (r_kind)
                            KIND_ADDR_W: begin
                                n_shift = r_reg;
                                n_kind  = KIND_REG;
                                n_bit   = 3'd0;
                                n_phase = PH_TX_LOW;
                            end
                            KIND_REG: begin
                                if (r_is_read) begin
                                    n_shift = {i_dev_addr, 1'b1};
                                    n_kind  = KIND_ADDR_R;
                                    n_phase = PH_REP_PREP;
                                end else begin
                                    n_kind  = KIND_DATA;
                                    n_phase = PH_WAIT_BYTE;
                                end
                            end
                            KIND_ADDR_R: begin
                                n_shift = 8'd0;
                                n_bit   = 3'd0;
                                n_phase = PH_RX_LOW;
                            end
                            default: begin
                                n_left  = left_dec;
                                n_phase = (left_dec == 8'd0) ? PH_STOP_LOW : PH_WAIT_BYTE;
                            end
                        endcase
                    end
                    PH_RX_LOW: n_phase = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        n_shift = rx_shift;
                        if (r_bit == 3'd7) begin
                            n_rx_hold  = rx_shift;
                            n_rx_final = (r_left <= 8'd1);
                            got        = 1'b1;
                            n_phase    = PH_MACK_LOW;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW: n_phase = PH_MACK_HIGH;
                    PH_MACK_HIGH: begin
                        n_left = left_dec;
                        if (left_dec == 8'd0) begin
                            n_phase = PH_STOP_LOW;
                        end else begin
                            n_shift = 8'd0;
                            n_bit   = 3'd0;
                            n_phase = PH_RX_LOW;
                        end
                    end
                    PH_STOP_LOW:  n_phase = PH_STOP_HIGH;
                    PH_STOP_HIGH: n_phase = PH_IDLE;
                    PH_REP_PREP:  n_phase = PH_START_HI;
                    default:      n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Bus levels follow the phase that the item leaves the sequencer in.
    always_comb begin
        case (n_phase)
            PH_START_LO: begin
                scl = 1'b1;
                sdo = 1'b0;
            end
            PH_TX_LOW: begin
                scl = 1'b0;
                sdo = n_shift[7];
            end
            PH_TX_HIGH: begin
                scl = 1'b1;
                sdo = n_shift[7];
            end
            PH_TACK_LOW, PH_RX_LOW, PH_REP_PREP, PH_WAIT_BYTE: begin
                scl = 1'b0;
                sdo = 1'b1;
            end
            PH_MACK_LOW: begin
                scl = 1'b0;
                sdo = (n_left <= 8'd1);
            end
            PH_MACK_HIGH: begin
                scl = 1'b1;
                sdo = (n_left <= 8'd1);
            end
            PH_STOP_LOW: begin
                scl = 1'b0;
                sdo = 1'b0;
            end
            PH_STOP_HIGH: begin
                scl = 1'b1;
                sdo = 1'b0;
            end
            default: begin
                scl = 1'b1;
                sdo = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_res.scl_level   = scl;
        o_res.sda_level   = sdo;
        o_res.read_byte   = n_rx_hold;
        o_res.read_valid  = got;
        o_res.need_byte   = (n_phase == PH_WAIT_BYTE) && !n_ready;
        o_res.ack_missing = n_nack;
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.last_byte   = n_rx_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_div      <= 8'd0;
            r_bit      <= 3'd0;
            r_shift    <= 8'd0;
            r_left     <= 8'd0;
            r_reg      <= 8'd0;
            r_is_read  <= 1'b0;
            r_ready    <= 1'b0;
            r_kind     <= KIND_ADDR_W;
            r_rx_hold  <= 8'd0;
            r_rx_final <= 1'b0;
            r_nack     <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_div      <= n_div;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_left     <= n_left;
            r_reg      <= n_reg;
            r_is_read  <= n_is_read;
            r_ready    <= n_ready;
            r_kind     <= n_kind;
            r_rx_hold  <= n_rx_hold;
            r_rx_final <= n_rx_final;
            r_nack     <= n_nack;
        end
    end

endmodule

[design/i2c_rbm_checker.sv]
// ============================================================================
// I2C register burst master - port checker
// Watches the top-level ports for a held stalled result and for bus levels
// that contradict the reported status.
// ============================================================================
module i2c_rbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // SCL is only pulled low inside a transaction.
    a_scl_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[13])
        else $error("SCL low while idle");

    // Waiting for a write byte parks SCL low with SDA released.
    a_wait_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[11] |->
        o_m_axis_tdata[13] && !o_m_axis_tdata[0] && o_m_axis_tdata[1])
        else $error("bad bus levels while waiting for a byte");

    // A completed read byte is followed by the low half of the ACK slot.
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[10] |->
        o_m_axis_tdata[13] && !o_m_axis_tdata[0] && !o_m_axis_tdata[11])
        else $error("read byte outside an ACK slot");

endmodule

bind i2c_register_burst_master i2c_rbm_checker u_i2c_rbm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the I2C register burst master
// Drives command and tick transfers into the stream input, predicts the bus
// levels and status of every result with a cycle-free model of the sequencer,
// and compares each result transfer field by field in order of arrival.
// ============================================================================
module testbench;
    import i2c_rbm_pkg::*;

    // The run is ended by the watchdog if it has not finished by then.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_RUNS    = 7;

    // One input transfer as the testbench sees it.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] count;
        logic [7:0] wbyte;
        logic       sda;
    } t_bus_cmd;

    // One row of the directed table. When typed is set, res is the result that
    // the row must produce; otherwise the predictor supplies it.
    typedef struct packed {
        t_bus_cmd cmd;
        logic     typed;
        t_result  res;
    } t_dir_row;

    // Results that can be read off directly: a quiet bus, the released lines
    // of the first start phase, and SDA pulled low under a high SCL (START).
    localparam t_result QUIET      = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam t_result START_HOLD = '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam t_result START_COND = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam t_result NO_TYPED   = '0;

    // The directed part runs on the reset settings: address 104, one tick per
    // phase. It covers idle ticks, a write byte that nobody asked for, a write
    // burst with a zero count, a begin while busy, and the first bits.
    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, QUIET},
        '{'{FUNC_TICK,     8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, QUIET},
        '{'{FUNC_WBYTE,    8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, QUIET},
        '{'{FUNC_BEGIN_WR, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, START_HOLD},
        '{'{FUNC_BEGIN_RD, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, START_HOLD},
        '{'{FUNC_WBYTE,    8'h5A, 8'h80, 8'hFF, 1'b0}, 1'b1, START_HOLD},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, START_COND},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'hA5, 8'h5A, 8'hC3, 1'b1}, 1'b0, NO_TYPED},
        '{'{FUNC_WBYTE,    8'h00, 8'h01, 8'h00, 1'b1}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TYPED},
        '{'{FUNC_BEGIN_WR, 8'h01, 8'h01, 8'h01, 1'b0}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TYPED},
        '{'{FUNC_BEGIN_RD, 8'h80, 8'h00, 8'h7F, 1'b1}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, NO_TYPED},
        '{'{FUNC_WBYTE,    8'h00, 8'h00, 8'h80, 1'b0}, 1'b0, NO_TYPED},
        '{'{FUNC_TICK,     8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TYPED}
    };

    // Settings of the random runs. A negative address means a random one.
    // The zero period runs as one tick; the 255-tick run is cut short while
    // the bus is still busy, so the following run finishes its transaction.
    localparam int RUN_ADDR  [NUM_RUNS] = '{104, 0, 127, -1, -1, 85, -1};
    localparam int RUN_TICKS [NUM_RUNS] = '{1, 2, 1, 0, 3, 255, 1};
    localparam int RUN_ITEMS [NUM_RUNS] = '{150, 150, 150, 120, 150, 260, 120};
    localparam bit RUN_CLOSE [NUM_RUNS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] in_data;
    logic [1:0]  in_func;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_data;
    logic        out_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    i2c_register_burst_master i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_func),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tlast  (out_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor of the sequencer. Its state is advanced once per accepted
    // input transfer, in the order of acceptance.
    // ------------------------------------------------------------------------
    logic [6:0]         dev_addr_q;
    logic [7:0]         half_period_q;
    logic [PHASE_W-1:0] bus_ph;
    logic [7:0]         div_cnt;
    logic [3:0]         bit_cnt;
    logic [7:0]         shreg;
    logic [7:0]         remaining;
    logic [7:0]         reg_latch;
    logic               rd_burst;
    logic               wbyte_held;
    logic [1:0]         tx_sel;
    logic [7:0]         rx_data;
    logic               rx_last;
    logic               nack_flag;

    // Expected results in the order their input transfers were accepted.
    t_result expected_levels [$];

    // Run statistics for the closing summary.
    int bursts_started;
    int bytes_supplied;
    int bytes_received;
    int nack_slots;
    int items_sent;
    int results_checked;
    int fails;
    int cycle_cnt;

    // Handles between the stimulus and the result sink.
    bit src_idle;
    bit snk_idle;
    int sink_hold;

    function automatic void clear_bus_model();
        dev_addr_q    = DEV_ADDR_RESET;
        half_period_q = TICKS_RESET;
        bus_ph        = PH_IDLE;
        div_cnt       = '0;
        bit_cnt       = '0;
        shreg         = '0;
        remaining     = '0;
        reg_latch     = '0;
        rd_burst      = 1'b0;
        wbyte_held    = 1'b0;
        tx_sel        = KIND_ADDR_W;
        rx_data       = '0;
        rx_last       = 1'b0;
        nack_flag     = 1'b0;
    endfunction

    // What happens when the ACK slot of a transmitted byte closes depends on
    // which byte it was: the register address follows the write address, a
    // read turns around with a repeated START, data bytes count down.
    function automatic void close_ack_slot();
        case (tx_sel)
            KIND_ADDR_W: begin
                shreg   = reg_latch;
                tx_sel  = KIND_REG;
                bit_cnt = '0;
                bus_ph  = PH_TX_LOW;
            end
            KIND_REG: begin
                if (rd_burst) begin
                    shreg  = {dev_addr_q, 1'b1};
                    tx_sel = KIND_ADDR_R;
                    bus_ph = PH_REP_PREP;
                end else begin
                    tx_sel = KIND_DATA;
                    bus_ph = PH_WAIT_BYTE;
                end
            end
            KIND_ADDR_R: begin
                shreg   = '0;
                bit_cnt = '0;
                bus_ph  = PH_RX_LOW;
            end
            default: begin
                if (remaining != 0) remaining--;
                bus_ph = (remaining == 0) ? PH_STOP_LOW : PH_WAIT_BYTE;
            end
        endcase
    endfunction

    // Leaves the current phase when its time is up. Returns 1 when a received
    // byte completes.
    function automatic logic end_of_phase(input logic sda);
        logic got;
        got = 1'b0;
        case (bus_ph)
            PH_START_HI: bus_ph = PH_START_LO;
            PH_START_LO: begin
                bit_cnt = '0;
                bus_ph  = PH_TX_LOW;
            end
            PH_TX_LOW: bus_ph = PH_TX_HIGH;
            PH_TX_HIGH: begin
                if (bit_cnt >= 4'd7) begin
                    bus_ph = PH_TACK_LOW;
                end else begin
                    bit_cnt++;
                    shreg  = shreg << 1;
                    bus_ph = PH_TX_LOW;
                end
            end
            PH_TACK_LOW: bus_ph = PH_TACK_HIGH;
            PH_TACK_HIGH: begin
                if (sda) begin
                    nack_flag = 1'b1;
                    nack_slots++;
                end
                close_ack_slot();
            end
            PH_RX_LOW: bus_ph = PH_RX_HIGH;
            PH_RX_HIGH: begin
                shreg = {shreg[6:0], sda};
                if (bit_cnt >= 4'd7) begin
                    rx_data = shreg;
                    rx_last = (remaining <= 8'd1);
                    got     = 1'b1;
                    bus_ph  = PH_MACK_LOW;
                end else begin
                    bit_cnt++;
                    bus_ph = PH_RX_LOW;
                end
            end
            PH_MACK_LOW: bus_ph = PH_MACK_HIGH;
            PH_MACK_HIGH: begin
                if (remaining != 0) remaining--;
                if (remaining == 0) begin
                    bus_ph = PH_STOP_LOW;
                end else begin
                    shreg   = '0;
                    bit_cnt = '0;
                    bus_ph  = PH_RX_LOW;
                end
            end
            PH_STOP_LOW:  bus_ph = PH_STOP_HIGH;
            PH_STOP_HIGH: bus_ph = PH_IDLE;
            PH_REP_PREP:  bus_ph = PH_START_HI;
            default:      bus_ph = PH_IDLE;
        endcase
        return got;
    endfunction

    // Applies one accepted transfer to the model and returns the result the
    // block must produce for it.
    function automatic t_result predict_levels(input t_bus_cmd c);
        t_result    r;
        logic       got;
        logic [7:0] period;
        got    = 1'b0;
        period = (half_period_q == 0) ? 8'd1 : half_period_q;
        if (c.func == FUNC_BEGIN_WR || c.func == FUNC_BEGIN_RD) begin
            // A begin is taken only on an idle bus.
            if (bus_ph == PH_IDLE) begin
                reg_latch  = c.reg_addr;
                remaining  = (c.count == 0) ? 8'd1 : c.count;
                rd_burst   = (c.func == FUNC_BEGIN_RD);
                shreg      = {dev_addr_q, 1'b0};
                tx_sel     = KIND_ADDR_W;
                bit_cnt    = '0;
                wbyte_held = 1'b0;
                div_cnt    = '0;
                nack_flag  = 1'b0;
                bus_ph     = PH_START_HI;
                bursts_started++;
            end
        end else if (c.func == FUNC_WBYTE) begin
            if (bus_ph == PH_WAIT_BYTE && !wbyte_held) begin
                shreg      = c.wbyte;
                wbyte_held = 1'b1;
                bytes_supplied++;
            end
        end else if (bus_ph == PH_WAIT_BYTE) begin
            // A tick in the byte wait only launches a byte already supplied.
            if (wbyte_held) begin
                wbyte_held = 1'b0;
                div_cnt    = '0;
                tx_sel     = KIND_DATA;
                bit_cnt    = '0;
                bus_ph     = PH_TX_LOW;
            end
        end else if (bus_ph != PH_IDLE) begin
            if ({1'b0, div_cnt} + 9'd1 >= {1'b0, period}) begin
                div_cnt = '0;
                got     = end_of_phase(c.sda);
            end else begin
                div_cnt++;
            end
        end
        if (got) bytes_received++;

        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        case (bus_ph)
            PH_START_LO: r.sda_level = 1'b0;
            PH_TX_LOW: begin
                r.scl_level = 1'b0;
                r.sda_level = shreg[7];
            end
            PH_TX_HIGH: r.sda_level = shreg[7];
            PH_TACK_LOW, PH_RX_LOW, PH_REP_PREP, PH_WAIT_BYTE: r.scl_level = 1'b0;
            PH_MACK_LOW: begin
                r.scl_level = 1'b0;
                r.sda_level = (remaining <= 8'd1);
            end
            PH_MACK_HIGH: r.sda_level = (remaining <= 8'd1);
            PH_STOP_LOW: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
            end
            PH_STOP_HIGH: r.sda_level = 1'b0;
            default: ;
        endcase
        r.read_byte   = rx_data;
        r.read_valid  = got;
        r.need_byte   = (bus_ph == PH_WAIT_BYTE) && !wbyte_held;
        r.ack_missing = nack_flag;
        r.busy_res    = (bus_ph != PH_IDLE);
        r.last_byte   = rx_last;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus selection. Commands follow the bus state so that most traffic
    // is well-formed transactions; a small share is noise the block ignores.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 8'd0;
        if (roll < 70) return 8'($urandom_range(1, 3));
        if (roll < 92) return 8'($urandom_range(4, 8));
        return 8'($urandom_range(9, 24));
    endfunction

    function automatic t_bus_cmd pick_cmd(input bit closing);
        t_bus_cmd c;
        int       roll;
        c.func     = FUNC_TICK;
        c.reg_addr = 8'($urandom_range(0, 255));
        c.count    = 8'($urandom_range(0, 255));
        c.wbyte    = 8'($urandom_range(0, 255));
        c.sda      = 1'($urandom_range(0, 1));
        roll       = $urandom_range(0, 99);
        if (bus_ph == PH_IDLE) begin
            if (roll < 80) begin
                c.func  = (roll < 40) ? FUNC_BEGIN_WR : FUNC_BEGIN_RD;
                c.count = pick_count();
            end else if (roll < 90) begin
                c.func = FUNC_WBYTE;
            end
        end else if (bus_ph == PH_WAIT_BYTE && !wbyte_held) begin
            // Mostly supply the byte; sometimes let time try to pass, or
            // send a begin that must be ignored.
            if (closing || roll < 75) c.func = FUNC_WBYTE;
            else if (roll >= 90) c.func = (roll < 95) ? FUNC_BEGIN_WR : FUNC_BEGIN_RD;
        end else if (!closing && roll < 6) begin
            c.func = (roll < 3) ? FUNC_WBYTE : FUNC_BEGIN_RD;
        end else if (bus_ph == PH_TACK_LOW || bus_ph == PH_TACK_HIGH) begin
            // The target usually acknowledges; one slot in ten is missed.
            c.sda = ($urandom_range(0, 9) == 0);
        end
        return c;
    endfunction

    // True when the transfer does something to the sequencer.
    function automatic bit moves_engine(input t_bus_cmd c);
        if (c.func == FUNC_BEGIN_WR || c.func == FUNC_BEGIN_RD) return bus_ph == PH_IDLE;
        if (c.func == FUNC_WBYTE) return bus_ph == PH_WAIT_BYTE && !wbyte_held;
        return bus_ph != PH_IDLE && !(bus_ph == PH_WAIT_BYTE && !wbyte_held);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Every call is entered just after a rising edge and leaves at
    // the edge where its transfer was accepted, with valid still high, so
    // back-to-back transfers keep valid asserted.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_bus_cmd c, input bit use_typed, input t_result typed_res);
        int      gap;
        t_result r;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= c.func;
        in_data  <= {7'd0, c.sda, c.wbyte, c.count, c.reg_addr};
        do @(posedge clk); while (!in_ready);
        r = predict_levels(c);
        expected_levels.push_back(use_typed ? typed_res : r);
        items_sent++;
    endtask

    // Stops offering transfers and waits until every result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_levels.size() != 0);
    endtask

    // Writes both registers back to back; valid stays high between them.
    task automatic write_settings(input logic [7:0] addr_val, input logic [7:0] ticks_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEV_ADDR;
        cfg_data  <= addr_val;
        do @(posedge clk); while (!cfg_ready);
        dev_addr_q = addr_val[6:0];
        cfg_index <= CFG_TICKS;
        cfg_data  <= ticks_val;
        do @(posedge clk); while (!cfg_ready);
        half_period_q = ticks_val;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_levels.size() == 0) begin
            fails++;
            $display("%0t: result transfer with nothing expected, expected none, got %0h",
                     $time, out_data);
        end else begin
            want = expected_levels.pop_front();
            check_field("scl_level",   8'(want.scl_level),   8'(out_data[0]));
            check_field("sda_level",   8'(want.sda_level),   8'(out_data[1]));
            check_field("read_byte",   want.read_byte,       out_data[9:2]);
            check_field("read_valid",  8'(want.read_valid),  8'(out_data[10]));
            check_field("need_byte",   8'(want.need_byte),   8'(out_data[11]));
            check_field("ack_missing", 8'(want.ack_missing), 8'(out_data[12]));
            check_field("busy_res",    8'(want.busy_res),    8'(out_data[13]));
            check_field("pad bits",    8'd0,                 8'(out_data[15:14]));
            check_field("last_byte",   8'(want.last_byte),   8'(out_last));
            results_checked++;
        end
    endtask

    // The sink draws a stall before every result. When the stimulus asks for
    // a hold, it keeps ready low for the requested hold instead, which lets the
    // block fill up and push back on the input side.
    initial begin : result_sink
        int wait_cycles;
        out_ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (sink_hold > 0) begin
                wait_cycles = sink_hold;
                sink_hold   = 0;
            end else begin
                wait_cycles = snk_idle ? $urandom_range(0, 6) : 0;
            end
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_result();
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random runs, each under
    // its own register settings.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_bus_cmd   c;
        int         moved;
        logic [7:0] addr_val;
        bit         hold_done;
        bit         pause_done;

        bursts_started  = 0;
        bytes_supplied  = 0;
        bytes_received  = 0;
        nack_slots      = 0;
        items_sent      = 0;
        results_checked = 0;
        fails           = 0;
        sink_hold       = 0;
        hold_done       = 1'b0;
        pause_done      = 1'b0;
        src_idle        = 1'b1;
        snk_idle        = 1'b1;
        clear_bus_model();

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_func   <= FUNC_TICK;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEV_ADDR;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The directed rows run on the reset settings.
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].res);
        end

        for (int run = 0; run < NUM_RUNS; run++) begin
            // The first run keeps the reset settings; the others are written
            // only once every result of the previous run has come back.
            if (run != 0) begin
                drain_results();
                addr_val = (RUN_ADDR[run] < 0) ? 8'($urandom_range(0, 255))
                                               : 8'(RUN_ADDR[run]);
                write_settings(addr_val, 8'(RUN_TICKS[run]));
            end
            moved = 0;
            while (moved < RUN_ITEMS[run]) begin
                c = pick_cmd(1'b0);
                if (moves_engine(c)) moved++;
                // Idling comes and goes in stretches, on either side.
                if (items_sent % 50 == 0) begin
                    src_idle = ($urandom_range(0, 2) != 0);
                    snk_idle = ($urandom_range(0, 2) != 0);
                end
                // Hold the sink for a long stretch while the source keeps
                // offering, so the block backs up into its input.
                if (run == 1 && moved == 40 && !hold_done) begin
                    hold_done = 1'b1;
                    sink_hold = 60;
                end
                // Pause the source until every outstanding result is back.
                if (run == 2 && moved == 100 && !pause_done) begin
                    pause_done = 1'b1;
                    drain_results();
                end
                send_item(c, 1'b0, NO_TYPED);
            end
            if (RUN_CLOSE[run]) begin
                while (bus_ph != PH_IDLE) send_item(pick_cmd(1'b1), 1'b0, NO_TYPED);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_levels.size() != 0) begin
            fails++;
            $display("%0t: %0d results never arrived, expected 0 left, got %0d",
                     $time, expected_levels.size(), expected_levels.size());
        end

        $display("Sent %0d transfers: %0d bursts, %0d bytes written, %0d bytes read,",
                 items_sent, bursts_started, bytes_supplied, bytes_received);
        $display("%0d missed acknowledges, %0d results checked, %0d mismatches.",
                 nack_slots, results_checked, fails);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
design/i2c_rbm_pkg.sv
design/i2c_rbm_cfg.sv
design/i2c_rbm_engine.sv
design/i2c_register_burst_master.sv
design/i2c_rbm_checker.sv
verif/testbench.sv
